// ----- rtl/lpss_pkg.sv -----
package lpss_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_t;

  localparam logic [7:0] HDR_LEN2 = 8'hFF;
  localparam logic [7:0] HDR_LEN4 = 8'hFE;
  localparam logic [7:0] HDR_LEN8 = 8'hFD;

  localparam logic [3:0] LEN2_BYTES = 4'd2;
  localparam logic [3:0] LEN4_BYTES = 4'd4;
  localparam logic [3:0] LEN8_BYTES = 4'd8;

  localparam int unsigned LEN_W = 64;

  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       section_first;
    logic       section_last;
    logic       buffer_end;
  } result_t;

endpackage

// ----- rtl/length_prefixed_section_splitter_unit.sv -----
// length prefixed section splitter
// input channel: one raw byte of the encoded buffer per word, with in_buffer_last
// on the buffer's final byte. a word is taken when in_valid is high and in_stall
// is low.
// result channel: zero or one word per input word, carrying out_kind (payload
// byte, empty section or buffer truncated), the payload byte with its first and
// last marks, and out_buffer_end. taken when out_valid is high and out_stall low.
// a result passes the input register, then the result register, and is offered
// from then on. throughput: one word per cycle while in_stall stays low, set by
// the single header/length/payload step between them.
// reset (synchronous, rst_n low): both channels empty, parser waits for a header.
// when the receiver stalls, the result register holds; the input register still
// drains words that give no result, and in_stall rises once a word is waiting
// behind a held result.
module length_prefixed_section_splitter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_buffer_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic       out_section_first,
  output logic       out_section_last,
  output logic       out_buffer_end
);
  import lpss_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  result_t    res;
  result_t    out_r;
  logic       out_valid_r;
  logic       out_free;
  logic       advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (out_free || !res.emit);
  assign in_stall = s1_valid_r && !advance;

  lpss_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .in_byte     (s1_byte_r),
    .buffer_last (s1_last_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_buffer_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_section_first = out_r.section_first;
  assign out_section_last  = out_r.section_last;
  assign out_buffer_end    = out_r.buffer_end;

  a_trunc_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TRUNC |-> out_buffer_end)
    else $error("truncated result without buffer end");

  a_marks_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |->
      !out_section_first && !out_section_last && out_payload_byte == 8'd0)
    else $error("section marks on a non-payload result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.emit |=> out_valid)
    else $error("result lost between core and result register");

endmodule

// ----- rtl/lpss_core.sv -----
module lpss_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             buffer_last,
  output lpss_pkg::result_t res
);
  import lpss_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       lbl_r, lbl_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             at_start_r, at_start_nxt;

  logic [LEN_W-1:0] shifted_len;
  logic [3:0]       lbl_dec;
  logic             closes;
  logic             is_ext_hdr;

  assign shifted_len = {left_r[LEN_W-9:0], in_byte};
  assign lbl_dec     = (lbl_r != 4'd0) ? lbl_r - 4'd1 : 4'd0;
  assign closes      = (left_r[LEN_W-1:1] == '0);
  assign is_ext_hdr  = in_byte inside {HDR_LEN2, HDR_LEN4, HDR_LEN8};

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    lbl_nxt      = lbl_r;
    left_nxt     = left_r;
    at_start_nxt = at_start_r;
    case (phase_r)
      PH_PAYLOAD: begin
        if (closes || buffer_last) begin
          phase_nxt    = PH_HEADER;
          lbl_nxt      = 4'd0;
          left_nxt     = '0;
          at_start_nxt = 1'b1;
        end else begin
          left_nxt     = left_r - {{(LEN_W-1){1'b0}}, 1'b1};
          at_start_nxt = 1'b0;
        end
      end
      PH_LENGTH: begin
        if (lbl_dec != 4'd0 && !buffer_last) begin
          lbl_nxt  = lbl_dec;
          left_nxt = shifted_len;
        end else if (lbl_dec == 4'd0 && shifted_len != '0 && !buffer_last) begin
          phase_nxt    = PH_PAYLOAD;
          lbl_nxt      = 4'd0;
          left_nxt     = shifted_len;
          at_start_nxt = 1'b1;
        end else begin
          phase_nxt    = PH_HEADER;
          lbl_nxt      = 4'd0;
          left_nxt     = '0;
          at_start_nxt = 1'b1;
        end
      end
      default: begin
        if (buffer_last || in_byte == 8'd0) begin
          phase_nxt    = PH_HEADER;
          lbl_nxt      = 4'd0;
          left_nxt     = '0;
          at_start_nxt = 1'b1;
        end else if (is_ext_hdr) begin
          phase_nxt = PH_LENGTH;
          left_nxt  = '0;
          case (in_byte)
            HDR_LEN2: lbl_nxt = LEN2_BYTES;
            HDR_LEN4: lbl_nxt = LEN4_BYTES;
            default:  lbl_nxt = LEN8_BYTES;
          endcase
        end else begin
          phase_nxt    = PH_PAYLOAD;
          left_nxt     = {{(LEN_W-8){1'b0}}, in_byte};
          at_start_nxt = 1'b1;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    res = '0;
    res.kind = KIND_PAYLOAD;
    case (phase_r)
      PH_PAYLOAD: begin
        res.emit = 1'b1;
        if (!closes && buffer_last) begin
          res.kind       = KIND_TRUNC;
          res.buffer_end = 1'b1;
        end else begin
          res.payload_byte  = in_byte;
          res.section_first = at_start_r;
          res.section_last  = closes;
          res.buffer_end    = buffer_last;
        end
      end
      PH_LENGTH: begin
        if (lbl_dec == 4'd0 && shifted_len == '0) begin
          res.emit       = 1'b1;
          res.kind       = KIND_EMPTY;
          res.buffer_end = buffer_last;
        end else if (buffer_last) begin
          res.emit       = 1'b1;
          res.kind       = KIND_TRUNC;
          res.buffer_end = 1'b1;
        end
      end
      default: begin
        if (in_byte == 8'd0) begin
          res.emit       = 1'b1;
          res.kind       = KIND_EMPTY;
          res.buffer_end = buffer_last;
        end else if (buffer_last) begin
          res.emit       = 1'b1;
          res.kind       = KIND_TRUNC;
          res.buffer_end = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      lbl_r      <= 4'd0;
      left_r     <= '0;
      at_start_r <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      lbl_r      <= lbl_nxt;
      left_r     <= left_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> at_start_r && lbl_r == 4'd0 && left_r == '0)
    else $error("idle state not cleared");

  a_length_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LENGTH |-> lbl_r != 4'd0)
    else $error("length phase with no length bytes left");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != '0)
    else $error("payload phase with zero bytes left");

endmodule
